@@ sv/nearest_timestamp_imu_pairing_defines.svh @@
// ----------------------------------------------------------------------------
// nearest_timestamp_imu_pairing_defines.svh
// Assertion macros for the IMU pairing block.
// ----------------------------------------------------------------------------
`ifndef NEAREST_TIMESTAMP_IMU_PAIRING_DEFINES_SVH
`define NEAREST_TIMESTAMP_IMU_PAIRING_DEFINES_SVH

// same-cycle implication
`define NTIP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NTIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ntip_pkg.sv @@
// ----------------------------------------------------------------------------
// ntip_pkg
// Shared constants and types of the IMU pairing block.
// ----------------------------------------------------------------------------
`default_nettype none

package ntip_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TIME_W = 48;
    localparam int WORD_W = 32;

    localparam int S_DATA_W = TIME_W + 3 * WORD_W;
    localparam int M_DATA_W = TIME_W + 6 * WORD_W;

    localparam logic [WORD_W-1:0] MATCH_WINDOW_RESET = 32'd9999000;

    localparam logic CMD_GYRO  = 1'b0;
    localparam logic CMD_ACCEL = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] x;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic start;
        logic vld;
    } scan_ctrl_t;

    typedef struct packed {
        logic              found;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
    } match_t;

endpackage

`default_nettype wire

@@ sv/ntip_cell.sv @@
// ----------------------------------------------------------------------------
// ntip_cell
// One window slot: holds a gyro entry and its valid bit, passes both on
// to the next slot on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ntip_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift,
    input  wire logic            vld_in,
    input  wire ntip_pkg::entry_t ent_in,
    output logic                 vld_out,
    output ntip_pkg::entry_t     ent_out
);
    import ntip_pkg::*;

    logic   vld_reg;
    entry_t ent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (shift)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            ent_reg <= ent_in;
        end
    end

    assign vld_out = vld_reg;
    assign ent_out = ent_reg;

endmodule

`default_nettype wire

@@ sv/ntip_scan.sv @@
// ----------------------------------------------------------------------------
// ntip_scan
// Nearest-entry search unit at the tail of the window: a gap stage and a
// best-so-far stage, fed one entry per cycle from oldest to newest.
// ----------------------------------------------------------------------------
`default_nettype none

module ntip_scan (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ntip_pkg::scan_ctrl_t         ctrl,
    input  wire ntip_pkg::entry_t             entry,
    input  wire logic [ntip_pkg::TIME_W-1:0]  acc_time,
    input  wire logic [ntip_pkg::WORD_W-1:0]  window,
    output ntip_pkg::match_t                  result
);
    import ntip_pkg::*;

    logic [TIME_W-1:0] gap_next;
    logic              gap_vld_reg;
    logic [TIME_W-1:0] gap_reg;
    logic [WORD_W-1:0] gx_reg;
    logic [WORD_W-1:0] gy_reg;
    logic [WORD_W-1:0] gz_reg;
    logic [TIME_W-1:0] best_reg;
    logic              found_reg;
    logic [WORD_W-1:0] rx_reg;
    logic [WORD_W-1:0] ry_reg;
    logic [WORD_W-1:0] rz_reg;
    logic              take;

    always_comb
    begin
        if (acc_time >= entry.stamp)
        begin
            gap_next = acc_time - entry.stamp;
        end
        else
        begin
            gap_next = entry.stamp - acc_time;
        end
    end

    assign take = gap_vld_reg && (gap_reg < best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else if (ctrl.start)
        begin
            gap_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            gap_vld_reg <= ctrl.vld;
            if (take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gap_reg <= gap_next;
        gx_reg  <= entry.x;
        gy_reg  <= entry.y;
        gz_reg  <= entry.z;
        if (ctrl.start)
        begin
            best_reg <= {{(TIME_W - WORD_W){1'b0}}, window};
            rx_reg   <= '0;
            ry_reg   <= '0;
            rz_reg   <= '0;
        end
        else if (take)
        begin
            best_reg <= gap_reg;
            rx_reg   <= gx_reg;
            ry_reg   <= gy_reg;
            rz_reg   <= gz_reg;
        end
    end

    assign result.found = found_reg;
    assign result.x     = rx_reg;
    assign result.y     = ry_reg;
    assign result.z     = rz_reg;

endmodule

`default_nettype wire

@@ sv/nearest_timestamp_imu_pairing.sv @@
// ----------------------------------------------------------------------------
// nearest_timestamp_imu_pairing
// Pairs each accelerometer sample with the closest-in-time gyro sample
// held in a shifting window of DEPTH slots.
// After a gyro transfer the next transfer can be taken right away. An accel
// transfer blocks input while all DEPTH slots shift past the search unit
// and through its two stages; input is taken again, and the paired record
// registered, once the output register is free.
// Reset empties the window, drops any pending record and loads the default
// match window.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_timestamp_imu_pairing_defines.svh"

module nearest_timestamp_imu_pairing (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ntip_pkg::WORD_W-1:0]    cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // sample_time, axis_x, axis_y, axis_z
    input  wire logic [ntip_pkg::S_DATA_W-1:0]  s_tdata,
    // command
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // pair_time, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z
    output logic [ntip_pkg::M_DATA_W-1:0]       m_tdata,
    // gyro_found
    output logic                                m_tuser
);
    import ntip_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [WORD_W-1:0]   match_window_reg;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tuser_reg;
    logic [TIME_W-1:0]   acc_time_reg;
    logic [WORD_W-1:0]   acc_x_reg;
    logic [WORD_W-1:0]   acc_y_reg;
    logic [WORD_W-1:0]   acc_z_reg;

    logic                in_xfer;
    logic                gyro_xfer;
    logic                accel_xfer;
    logic                out_free;
    logic                chain_shift;
    logic [DEPTH:0]      vld_link;
    entry_t              ent_link [DEPTH+1];
    scan_ctrl_t          scan_ctrl;
    match_t              match;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE) || ((state_reg == ST_FINISH) && out_free);
    assign in_xfer    = s_tvalid && s_tready;
    assign gyro_xfer  = in_xfer && (s_tuser != CMD_ACCEL);
    assign accel_xfer = in_xfer && (s_tuser == CMD_ACCEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_window_reg <= MATCH_WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            match_window_reg <= cfg_wdata;
        end
    end

    // window: newest enters at slot 0, oldest falls off the far end
    assign chain_shift    = gyro_xfer || (state_reg == ST_SCAN);
    assign vld_link[0]    = gyro_xfer;
    assign ent_link[0]    = entry_t'(s_tdata);

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        ntip_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (chain_shift),
            .vld_in  (vld_link[i]),
            .ent_in  (ent_link[i]),
            .vld_out (vld_link[i+1]),
            .ent_out (ent_link[i+1])
        );
    end

    assign scan_ctrl.start = accel_xfer;
    assign scan_ctrl.vld   = (state_reg == ST_SCAN) && vld_link[DEPTH];

    ntip_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (scan_ctrl),
        .entry    (ent_link[DEPTH]),
        .acc_time (acc_time_reg),
        .window   (match_window_reg),
        .result   (match)
    );

    always_ff @(posedge clk)
    begin
        if (accel_xfer)
        begin
            acc_time_reg <= s_tdata[TIME_W-1:0];
            acc_x_reg    <= s_tdata[TIME_W +: WORD_W];
            acc_y_reg    <= s_tdata[TIME_W + WORD_W +: WORD_W];
            acc_z_reg    <= s_tdata[TIME_W + 2 * WORD_W +: WORD_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !((state_reg == ST_FINISH) && out_free))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accel_xfer)
                    begin
                        state_reg <= ST_SCAN;
                        cnt_reg   <= '0;
                    end
                end
                ST_SCAN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DEPTH - 1))
                    begin
                        state_reg <= ST_FLUSH;
                    end
                end
                ST_FLUSH:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= match.found;
                        m_tdata_reg  <= {acc_z_reg, acc_y_reg, acc_x_reg,
                                         match.z, match.y, match.x, acc_time_reg};
                        if (accel_xfer)
                        begin
                            state_reg <= ST_SCAN;
                            cnt_reg   <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `NTIP_ASSERT_NEXT(a_accel_blocks_input, accel_xfer, !s_tready,
        "input taken during accel search")
    `NTIP_ASSERT_NOW(a_window_empty_at_finish, state_reg == ST_FINISH,
        vld_link[DEPTH:1] == '0, "window not empty after search")
    `NTIP_ASSERT_NOW(a_no_match_zero_rates, m_tvalid && !m_tuser,
        m_tdata[TIME_W + 3 * WORD_W - 1:TIME_W] == '0, "rates nonzero without match")

endmodule

`default_nettype wire
